// ===== sv/csf_pkg.sv =====
package csf_pkg;

  // Filter order (number of states in use), 1..4
  localparam int Order    = 4;
  // Coefficient registers per bank, fixed by the register map
  localparam int NumCoef  = 4;

  localparam int CoefW    = 16;
  localparam int StateW   = 24;
  localparam int SmpW     = 16;
  localparam int FracBits = 14;

  localparam int ProdW    = CoefW + StateW;
  localparam int AccW     = ProdW + $clog2(Order) + 1;
  localparam int RndW     = AccW - FracBits;
  localparam int DiffW    = RndW + 1;
  localparam int KW       = (Order > 1) ? $clog2(Order) : 1;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  localparam int StateMax = 2 ** (StateW - 1) - 1;
  localparam int StateMin = -(2 ** (StateW - 1));
  localparam int SmpMax   = 2 ** (SmpW - 1) - 1;
  localparam int SmpMin   = -(2 ** (SmpW - 1));

  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic signed [StateW-1:0] stv_t;
  typedef logic signed [SmpW-1:0]   smp_t;
  typedef logic signed [AccW-1:0]   acc_t;

  // MAC issue control
  typedef struct packed {
    logic issue;  // a product is issued this cycle
    logic first;  // first product of a dot product: reload accumulator
  } mac_ctl_t;

  function automatic stv_t sat_state(logic signed [DiffW-1:0] v);
    logic signed [DiffW-1:0] hi;
    logic signed [DiffW-1:0] lo;
    hi = DiffW'(StateMax);
    lo = DiffW'(StateMin);
    if (v > hi) begin
      return hi[StateW-1:0];
    end else if (v < lo) begin
      return lo[StateW-1:0];
    end
    return v[StateW-1:0];
  endfunction

  function automatic smp_t sat_out(logic signed [RndW-1:0] v);
    logic signed [RndW-1:0] hi;
    logic signed [RndW-1:0] lo;
    hi = RndW'(SmpMax);
    lo = RndW'(SmpMin);
    if (v > hi) begin
      return hi[SmpW-1:0];
    end else if (v < lo) begin
      return lo[SmpW-1:0];
    end
    return v[SmpW-1:0];
  endfunction

endpackage

// ===== sv/csf_in_if.sv =====
interface csf_in_if;
  logic          valid;
  logic          ready;
  csf_pkg::smp_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== sv/csf_out_if.sv =====
interface csf_out_if;
  logic          valid;
  logic          ready;
  csf_pkg::smp_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== sv/csf_mac.sv =====
// Shared multiply-accumulate: product register, then accumulator.
// Accumulator is preloaded with the rounding bias on the first product.
module csf_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csf_pkg::mac_ctl_t ctl_i,
  input  csf_pkg::coef_t    coef_i,
  input  csf_pkg::stv_t     state_i,
  output csf_pkg::acc_t     acc_o
);

  localparam csf_pkg::acc_t RoundBias = csf_pkg::AccW'(2 ** (csf_pkg::FracBits - 1));

  logic signed [csf_pkg::ProdW-1:0] prod_d;
  logic signed [csf_pkg::ProdW-1:0] prod_q;
  logic                             pv_q;
  logic                             first_q;
  csf_pkg::acc_t                    acc_q;

  assign prod_d = coef_i * state_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      first_q <= 1'b0;
    end else begin
      pv_q    <= ctl_i.issue;
      first_q <= ctl_i.first;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (pv_q) begin
      acc_q <= (first_q ? RoundBias : acc_q) + csf_pkg::AccW'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== sv/canonical_state_space_filter.sv =====
// Channel | Dir | Payload            | Transfer
// in_i    | in  | sample_in  (s16)   | valid & ready
// out_o   | out | sample_out (s16)   | valid & ready
// cfg     | in  | cfg_idx_i/cfg_data | cfg_we_i, one write per cycle
//
// From acceptance to the next ready, a sample passes through the denominator
// pass, where the single shared MAC takes one product per cycle, a drain state
// for its two-stage pipeline, the state update, the numerator pass with its
// own drain state, and the output register load. A new sample is accepted
// only once the sequencer is back in idle after that load.
// rst_ni clears states, coefficients, sequencer and the output register.
// The result sits in an output register; a new sample is accepted while it
// waits, but that sample's result stalls in the final step until the slot frees.
module canonical_state_space_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  csf_in_if.sink                        in_i,
  csf_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [csf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [csf_pkg::CfgDataW-1:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StDen,       // issue den_coef[k] * state[k]
    StDenDrain,  // last denominator product accumulates
    StUpd,       // shift states, new last state
    StNum,       // issue num_coef[k] * new state[k]
    StNumDrain,
    StOut        // round, saturate, load output register
  } fsm_e;

  localparam int Ord = csf_pkg::Order;
  localparam int KW  = csf_pkg::KW;

  fsm_e                          state_q;
  logic [KW-1:0]                 k_q;
  csf_pkg::smp_t                 u_q;
  csf_pkg::stv_t                 st_q [Ord];
  csf_pkg::coef_t                den_q [Ord];
  csf_pkg::coef_t                num_q [Ord];
  logic                          out_vld_q;
  csf_pkg::smp_t                 out_data_q;

  csf_pkg::mac_ctl_t             mac_ctl;
  csf_pkg::coef_t                mac_coef;
  csf_pkg::acc_t                 acc;
  logic signed [csf_pkg::RndW-1:0]  rnd;
  logic signed [csf_pkg::DiffW-1:0] diff;
  csf_pkg::stv_t                 new_st;
  logic                          k_last;
  logic                          out_free;
  logic                          load_out;
  logic [csf_pkg::CfgIdxW-1:0]   num_idx;

  // ---------------------------------------------------------------------------
  // Coefficient registers. Indices past the used order or past the map are
  // dropped.
  // ---------------------------------------------------------------------------
  assign num_idx = cfg_idx_i - csf_pkg::CfgIdxW'(csf_pkg::NumCoef);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Ord; i++) begin
        den_q[i] <= '0;
        num_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < csf_pkg::CfgIdxW'(Ord)) begin
        den_q[cfg_idx_i[KW-1:0]] <= cfg_data_i;
      end else if (cfg_idx_i >= csf_pkg::CfgIdxW'(csf_pkg::NumCoef) &&
                   num_idx < csf_pkg::CfgIdxW'(Ord)) begin
        num_q[num_idx[KW-1:0]] <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared MAC
  // ---------------------------------------------------------------------------
  assign k_last        = (k_q == KW'(Ord - 1));
  assign mac_ctl.issue = (state_q == StDen) || (state_q == StNum);
  assign mac_ctl.first = (k_q == '0);
  assign mac_coef      = (state_q == StDen) ? den_q[k_q] : num_q[k_q];

  csf_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .coef_i  (mac_coef),
    .state_i (st_q[k_q]),
    .acc_o   (acc)
  );

  // Accumulator already carries the half-LSB bias: the shift rounds half up.
  assign rnd    = $signed(acc[csf_pkg::AccW-1:csf_pkg::FracBits]);
  assign diff   = csf_pkg::DiffW'(u_q) - csf_pkg::DiffW'(rnd);
  assign new_st = csf_pkg::sat_state(diff);

  // Output slot is free when empty or being drained this cycle
  assign out_free = !out_vld_q || out_o.ready;
  assign load_out = (state_q == StOut) && out_free;

  // ---------------------------------------------------------------------------
  // Sequencer, states, output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      k_q        <= '0;
      u_q        <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      for (int i = 0; i < Ord; i++) begin
        st_q[i] <= '0;
      end
    end else begin
      // load wins over drain: a drained slot is refilled in the same cycle
      if (load_out) begin
        out_vld_q  <= 1'b1;
        out_data_q <= csf_pkg::sat_out(rnd);
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            u_q     <= in_i.sample_in;
            k_q     <= '0;
            state_q <= StDen;
          end
        end
        StDen: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= StDenDrain;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        StDenDrain: begin
          state_q <= StUpd;
        end
        StUpd: begin
          for (int i = 0; i < Ord - 1; i++) begin
            st_q[i] <= st_q[i+1];
          end
          st_q[Ord-1] <= new_st;
          state_q     <= StNum;
        end
        StNum: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= StNumDrain;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        StNumDrain: begin
          state_q <= StOut;
        end
        StOut: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_i.ready       = (state_q == StIdle);
  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == StDen && k_q == '0)
    else $error("accepted transaction did not start the denominator pass");

  a_last_state_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StUpd |=> st_q[Ord-1] == $past(new_st))
    else $error("last state not loaded with the saturated update");

  a_num_pass_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StNum && k_last |=> state_q == StNumDrain)
    else $error("numerator pass did not end after Order products");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut && out_vld_q && !out_o.ready |=> state_q == StOut && out_vld_q)
    else $error("pending result overwritten or dropped");

endmodule
